// ===== rtl/sql_leading_keyword_classifier_macros.svh =====
// Assertion macros for the SQL leading-keyword classifier.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef SQL_LEADING_KEYWORD_CLASSIFIER_MACROS_SVH
`define SQL_LEADING_KEYWORD_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLKC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slkc assertion failed");
// next-cycle implication
`define SLKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slkc assertion failed");
`else
`define SLKC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLKC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/slkc_pkg.sv =====
// Shared types, keyword tables and helper functions for the SQL
// leading-keyword classifier. No dependencies.
`timescale 1ns / 1ps
package slkc_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic       gives_rows;
        logic [3:0] keyword_code;
    } result_t;

    localparam int KW_NUM    = 8;
    localparam int KW_MAXLEN = 9;

    localparam logic [3:0] LEN_MAX = 4'd15;

    localparam logic [3:0] KW_NONE      = 4'd0;
    localparam logic [3:0] KW_SELECT    = 4'd1;
    localparam logic [3:0] KW_WITH      = 4'd2;
    localparam logic [3:0] KW_PRAGMA    = 4'd3;
    localparam logic [3:0] KW_VALUES    = 4'd4;
    localparam logic [3:0] KW_EXPLAIN   = 4'd5;
    localparam logic [3:0] KW_DESCRIBE  = 4'd6;
    localparam logic [3:0] KW_SUMMARIZE = 4'd7;
    localparam logic [3:0] KW_SHOW      = 4'd8;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CASE_FOLD = 8'hDF;

    typedef logic [7:0] kw_text_t [KW_MAXLEN];

    localparam kw_text_t KW_TEXT [KW_NUM] = '{
        '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00, 8'h00},
        '{"W", "I", "T", "H", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "R", "A", "G", "M", "A", 8'h00, 8'h00, 8'h00},
        '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00, 8'h00},
        '{"E", "X", "P", "L", "A", "I", "N", 8'h00, 8'h00},
        '{"D", "E", "S", "C", "R", "I", "B", "E", 8'h00},
        '{"S", "U", "M", "M", "A", "R", "I", "Z", "E"},
        '{"S", "H", "O", "W", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd6, 4'd4, 4'd6, 4'd6, 4'd7, 4'd8, 4'd9, 4'd4
    };

    localparam logic [3:0] KW_CODE [KW_NUM] = '{
        KW_SELECT, KW_WITH, KW_PRAGMA, KW_VALUES,
        KW_EXPLAIN, KW_DESCRIBE, KW_SUMMARIZE, KW_SHOW
    };

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    // drop every keyword that is shorter than pos+1 or whose letter at pos differs from up
    function automatic logic [KW_NUM-1:0] match_letter(
        input logic [KW_NUM-1:0] mask,
        input logic [3:0]        pos,
        input logic [7:0]        up
    );
        logic [KW_NUM-1:0] keep;
        for (int k = 0; k < KW_NUM; k++)
        begin
            keep[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == up);
        end
        return mask & keep;
    endfunction

endpackage

// ===== rtl/sql_leading_keyword_classifier.sv =====
// An end transaction waits in the input register; its result is presented from the result register.
// Throughput: one transaction per cycle; an end transaction waits only while a result is stalled.
// The scan state is one small state machine updated once per accepted character.
// Reset (rst_n, asynchronous, active low) empties both register stages and restarts the scan.
// Top level of the SQL leading-keyword classifier.
// Depends on slkc_pkg, slkc_in_reg, slkc_scanner and slkc_out_reg.
`timescale 1ns / 1ps
module sql_leading_keyword_classifier
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [0:0] s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] gives_rows, [4:1] keyword_code, [7:5] zero
);
    import slkc_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_space;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign s_item.kind = s_tuser[0];
    assign s_item.ch   = s_tdata;

    slkc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .out_space  (out_space),
        .item_valid (item_valid),
        .item       (item)
    );

    slkc_scanner u_scanner
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    slkc_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .space      (out_space),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {3'b000, m_res.keyword_code, m_res.gives_rows};

endmodule

// ===== rtl/slkc_in_reg.sv =====
// Input register stage of the SQL leading-keyword classifier.
// Depends on slkc_pkg.
`timescale 1ns / 1ps
module slkc_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  slkc_pkg::item_t s_item,
    input  logic            out_space,
    output logic            item_valid,
    output slkc_pkg::item_t item
);
    import slkc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  advance;

    // an end transaction needs a free result slot; characters always move on
    assign advance    = valid_reg && (!item_reg.kind || out_space);
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = advance;
    assign item       = item_reg;

endmodule

// ===== rtl/slkc_scanner.sv =====
// Scan state machine and keyword matcher of the SQL leading-keyword
// classifier. Depends on slkc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sql_leading_keyword_classifier_macros.svh"
module slkc_scanner
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  slkc_pkg::item_t   item,
    output logic              res_valid,
    output slkc_pkg::result_t res
);
    import slkc_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_DASH  = 3'd1,
        PH_SLASH = 3'd2,
        PH_LINE  = 3'd3,
        PH_BLOCK = 3'd4,
        PH_BSTAR = 3'd5,
        PH_WORD  = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [3:0]        length_reg;
    logic [3:0]        length_next;
    logic [KW_NUM-1:0] mask_reg;
    logic [KW_NUM-1:0] mask_next;
    logic [3:0]        match_code;
    logic [KW_NUM-1:0] mask_letter;
    logic [3:0]        length_letter;
    logic              letter;

    assign letter        = is_letter(item.ch);
    assign mask_letter   = match_letter(mask_reg, length_reg, item.ch & CASE_FOLD);
    assign length_letter = (length_reg == LEN_MAX) ? length_reg : length_reg + 4'd1;

    always_comb
    begin
        match_code = KW_NONE;
        if ((phase_reg == PH_WORD) || (phase_reg == PH_DONE))
        begin
            for (int k = 0; k < KW_NUM; k++)
            begin
                if (mask_reg[k] && (length_reg == KW_LEN[k]))
                begin
                    match_code = KW_CODE[k];
                end
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        length_next      = length_reg;
        mask_next        = mask_reg;
        res_valid        = 1'b0;
        res.gives_rows   = (match_code != KW_NONE);
        res.keyword_code = match_code;
        if (item_valid)
        begin
            if (item.kind)
            begin
                res_valid   = 1'b1;
                phase_next  = PH_SKIP;
                length_next = 4'd0;
                mask_next   = '1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if ((item.ch == CH_SPACE) || (item.ch == CH_TAB) ||
                            (item.ch == CH_LF) || (item.ch == CH_CR))
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (item.ch == CH_DASH)
                        begin
                            phase_next = PH_DASH;
                        end
                        else if (item.ch == CH_SLASH)
                        begin
                            phase_next = PH_SLASH;
                        end
                        else if (letter)
                        begin
                            mask_next   = mask_letter;
                            length_next = length_letter;
                            phase_next  = PH_WORD;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DASH:
                    begin
                        phase_next = (item.ch == CH_DASH) ? PH_LINE : PH_DONE;
                    end
                    PH_SLASH:
                    begin
                        phase_next = (item.ch == CH_STAR) ? PH_BLOCK : PH_DONE;
                    end
                    PH_LINE:
                    begin
                        if (item.ch == CH_LF)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_BLOCK:
                    begin
                        if (item.ch == CH_STAR)
                        begin
                            phase_next = PH_BSTAR;
                        end
                    end
                    PH_BSTAR:
                    begin
                        if (item.ch == CH_SLASH)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (item.ch != CH_STAR)
                        begin
                            phase_next = PH_BLOCK;
                        end
                    end
                    PH_WORD:
                    begin
                        if (letter)
                        begin
                            mask_next   = mask_letter;
                            length_next = length_letter;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP;
            length_reg <= 4'd0;
            mask_reg   <= '1;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            mask_reg   <= mask_next;
        end
    end

    `SLKC_ASSERT_NEXT(a_end_restarts, clk, rst_n, item_valid && item.kind,
        (phase_reg == PH_SKIP) && (length_reg == 4'd0) && (&mask_reg))
    `SLKC_ASSERT_NOW(a_long_word_no_match, clk, rst_n, length_reg > 4'd9,
        mask_reg == '0)
    `SLKC_ASSERT_NOW(a_code_needs_word, clk, rst_n, match_code != KW_NONE,
        (phase_reg == PH_WORD) || (phase_reg == PH_DONE))

endmodule

// ===== rtl/slkc_out_reg.sv =====
// Result register of the SQL leading-keyword classifier.
// Depends on slkc_pkg.
`timescale 1ns / 1ps
module slkc_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  slkc_pkg::result_t res,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output slkc_pkg::result_t m_res
);
    import slkc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = res_valid || (valid_reg && !m_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule
